>>> rtl/core/isd_pkg.sv
`timescale 1ns / 1ps

package isd_pkg;

    localparam int unsigned MEMORY_DEPTH_DEF = 4096;
    localparam int unsigned OLD_DEPTH        = 1024;
    localparam int unsigned QUEUE_DEPTH      = 4;

    localparam int unsigned ADDR_W = 12;
    localparam int unsigned WORD_W = 18;

    localparam logic [ADDR_W-1:0] SCRATCH_ADDR = 12'h380;

    // Record kinds.
    localparam logic [1:0] KIND_ORIGIN  = 2'd0;
    localparam logic [1:0] KIND_SCRATCH = 2'd1;
    localparam logic [1:0] KIND_INSTR   = 2'd2;
    localparam logic [1:0] KIND_DATA    = 2'd3;

    // Mnemonic classes.
    localparam logic [5:0] MN_MOVE = 6'd0;
    localparam logic [5:0] MN_STAR = 6'd1;
    localparam logic [5:0] MN_AND  = 6'd2;
    localparam logic [5:0] MN_OR   = 6'd3;
    localparam logic [5:0] MN_XOR  = 6'd4;
    localparam logic [5:0] MN_TEST = 6'd5;
    localparam logic [5:0] MN_TSTC = 6'd6;
    localparam logic [5:0] MN_ADD  = 6'd7;
    localparam logic [5:0] MN_ADDC = 6'd8;
    localparam logic [5:0] MN_SUB  = 6'd9;
    localparam logic [5:0] MN_SUBC = 6'd10;
    localparam logic [5:0] MN_COMP = 6'd11;
    localparam logic [5:0] MN_CMPC = 6'd12;
    localparam logic [5:0] MN_RL   = 6'd13;
    localparam logic [5:0] MN_SL0  = 6'd14;
    localparam logic [5:0] MN_SL1  = 6'd15;
    localparam logic [5:0] MN_SLA  = 6'd16;
    localparam logic [5:0] MN_SLX  = 6'd17;
    localparam logic [5:0] MN_RR   = 6'd18;
    localparam logic [5:0] MN_SR0  = 6'd19;
    localparam logic [5:0] MN_SR1  = 6'd20;
    localparam logic [5:0] MN_SRA  = 6'd21;
    localparam logic [5:0] MN_SRX  = 6'd22;
    localparam logic [5:0] MN_CORE = 6'd23;
    localparam logic [5:0] MN_JUMP = 6'd24;
    localparam logic [5:0] MN_CALL = 6'd25;
    localparam logic [5:0] MN_RET  = 6'd26;
    localparam logic [5:0] MN_ST   = 6'd27;
    localparam logic [5:0] MN_LD   = 6'd28;
    localparam logic [5:0] MN_OUT  = 6'd29;
    localparam logic [5:0] MN_OUTK = 6'd30;
    localparam logic [5:0] MN_IN   = 6'd31;
    localparam logic [5:0] MN_DINT = 6'd32;
    localparam logic [5:0] MN_EINT = 6'd33;
    localparam logic [5:0] MN_RETI = 6'd34;
    localparam logic [5:0] MN_BANK = 6'd35;
    localparam logic [5:0] MN_UNK  = 6'd36;

    // Operand forms.
    localparam logic [3:0] FM_NONE  = 4'd0;
    localparam logic [3:0] FM_RR    = 4'd1;
    localparam logic [3:0] FM_RC    = 4'd2;
    localparam logic [3:0] FM_REG   = 4'd3;
    localparam logic [3:0] FM_ADDR  = 4'd4;
    localparam logic [3:0] FM_CADDR = 4'd5;
    localparam logic [3:0] FM_COND  = 4'd6;
    localparam logic [3:0] FM_CNIB  = 4'd7;
    localparam logic [3:0] FM_RAW   = 4'd8;
    localparam logic [3:0] FM_FLAG  = 4'd9;

    // Conditions.
    localparam logic [1:0] CC_Z  = 2'd0;
    localparam logic [1:0] CC_NZ = 2'd1;
    localparam logic [1:0] CC_C  = 2'd2;
    localparam logic [1:0] CC_NC = 2'd3;

    // Whole words with a meaning of their own.
    localparam logic [WORD_W-1:0] OLD_DINT  = 18'h3C000;
    localparam logic [WORD_W-1:0] OLD_EINT  = 18'h3C001;
    localparam logic [WORD_W-1:0] OLD_RETI0 = 18'h38000;
    localparam logic [WORD_W-1:0] OLD_RETI1 = 18'h38001;
    localparam logic [WORD_W-1:0] NEW_DINT  = 18'h28000;
    localparam logic [WORD_W-1:0] NEW_EINT  = 18'h28001;
    localparam logic [WORD_W-1:0] NEW_RETI0 = 18'h29000;
    localparam logic [WORD_W-1:0] NEW_RETI1 = 18'h29001;
    localparam logic [WORD_W-1:0] NEW_BANK0 = 18'h37000;
    localparam logic [WORD_W-1:0] NEW_BANK1 = 18'h37001;

    typedef enum logic [1:0] {
        RG_IDLE,
        RG_CODE,
        RG_DATA
    } t_region;

    // One queued word with the classification made by the front end.
    typedef struct packed {
        logic              dir;
        logic              scratch;
        logic              data;
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } t_q_entry;

    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic [5:0] mnem;
        logic [3:0] form;
        logic [1:0] cond;
    } t_dec;

    typedef struct packed {
        logic [1:0]        record_kind;
        logic [5:0]        mnemonic;
        logic [3:0]        operand_form;
        logic [3:0]        first_reg;
        logic [3:0]        second_reg;
        logic [7:0]        constant_byte;
        logic [ADDR_W-1:0] target_address;
        logic [1:0]        condition;
        logic [3:0]        small_value;
        logic [7:0]        data_high;
        logic [WORD_W-1:0] raw_word;
        logic              last_of_run;
    } t_result;

    function automatic t_dec mk(input logic [5:0] m, input logic [3:0] f,
                                input logic [1:0] k);
        t_dec d;
        d.mnem = m;
        d.form = f;
        d.cond = k;
        return d;
    endfunction

    function automatic t_dec shift_code(input logic [3:0] s);
        t_dec d;
        case (s)
            4'h2:    d = mk(MN_RL,  FM_REG, CC_Z);
            4'h6:    d = mk(MN_SL0, FM_REG, CC_Z);
            4'h7:    d = mk(MN_SL1, FM_REG, CC_Z);
            4'h0:    d = mk(MN_SLA, FM_REG, CC_Z);
            4'h4:    d = mk(MN_SLX, FM_REG, CC_Z);
            4'hC:    d = mk(MN_RR,  FM_REG, CC_Z);
            4'hE:    d = mk(MN_SR0, FM_REG, CC_Z);
            4'hF:    d = mk(MN_SR1, FM_REG, CC_Z);
            4'h8:    d = mk(MN_SRA, FM_REG, CC_Z);
            4'hA:    d = mk(MN_SRX, FM_REG, CC_Z);
            default: d = mk(MN_UNK, FM_RAW, CC_Z);
        endcase
        return d;
    endfunction

    function automatic t_dec decode_old(input logic [WORD_W-1:0] c);
        t_dec       d;
        logic [1:0] k;
        k = c[11:10];
        case (c[17:12])
            6'h00:   d = mk(MN_MOVE, FM_RC, CC_Z);
            6'h01:   d = mk(MN_MOVE, FM_RR, CC_Z);
            6'h0A:   d = mk(MN_AND,  FM_RC, CC_Z);
            6'h0B:   d = mk(MN_AND,  FM_RR, CC_Z);
            6'h0C:   d = mk(MN_OR,   FM_RC, CC_Z);
            6'h0D:   d = mk(MN_OR,   FM_RR, CC_Z);
            6'h0E:   d = mk(MN_XOR,  FM_RC, CC_Z);
            6'h0F:   d = mk(MN_XOR,  FM_RR, CC_Z);
            6'h12:   d = mk(MN_TEST, FM_RC, CC_Z);
            6'h13:   d = mk(MN_TEST, FM_RR, CC_Z);
            6'h18:   d = mk(MN_ADD,  FM_RC, CC_Z);
            6'h19:   d = mk(MN_ADD,  FM_RR, CC_Z);
            6'h1A:   d = mk(MN_ADDC, FM_RC, CC_Z);
            6'h1B:   d = mk(MN_ADDC, FM_RR, CC_Z);
            6'h1C:   d = mk(MN_SUB,  FM_RC, CC_Z);
            6'h1D:   d = mk(MN_SUB,  FM_RR, CC_Z);
            6'h1E:   d = mk(MN_SUBC, FM_RC, CC_Z);
            6'h1F:   d = mk(MN_SUBC, FM_RR, CC_Z);
            6'h14:   d = mk(MN_COMP, FM_RC, CC_Z);
            6'h15:   d = mk(MN_COMP, FM_RR, CC_Z);
            6'h20:   d = shift_code(c[3:0]);
            6'h34:   d = mk(MN_JUMP, FM_ADDR, CC_Z);
            6'h35:   d = mk(MN_JUMP, FM_CADDR, k);
            6'h30:   d = mk(MN_CALL, FM_ADDR, CC_Z);
            6'h31:   d = mk(MN_CALL, FM_CADDR, k);
            6'h2A:   d = mk(MN_RET,  FM_NONE, CC_Z);
            6'h2B:   d = mk(MN_RET,  FM_COND, k);
            6'h2E:   d = mk(MN_ST,   FM_RC, CC_Z);
            6'h2F:   d = mk(MN_ST,   FM_RR, CC_Z);
            6'h06:   d = mk(MN_LD,   FM_RC, CC_Z);
            6'h07:   d = mk(MN_LD,   FM_RR, CC_Z);
            6'h2C:   d = mk(MN_OUT,  FM_RC, CC_Z);
            6'h2D:   d = mk(MN_OUT,  FM_RR, CC_Z);
            6'h04:   d = mk(MN_IN,   FM_RC, CC_Z);
            6'h05:   d = mk(MN_IN,   FM_RR, CC_Z);
            default: d = mk(MN_UNK,  FM_RAW, CC_Z);
        endcase
        if (c == OLD_DINT) begin
            d = mk(MN_DINT, FM_NONE, CC_Z);
        end else if (c == OLD_EINT) begin
            d = mk(MN_EINT, FM_NONE, CC_Z);
        end else if (c == OLD_RETI0 || c == OLD_RETI1) begin
            d = mk(MN_RETI, FM_FLAG, CC_Z);
        end
        return d;
    endfunction

    function automatic t_dec decode_new(input logic [WORD_W-1:0] c);
        t_dec d;
        case (c[17:12])
            6'h00:   d = mk(MN_MOVE, FM_RR, CC_Z);
            6'h01:   d = mk(MN_MOVE, FM_RC, CC_Z);
            6'h16:   d = mk(MN_STAR, FM_RR, CC_Z);
            6'h02:   d = mk(MN_AND,  FM_RR, CC_Z);
            6'h03:   d = mk(MN_AND,  FM_RC, CC_Z);
            6'h04:   d = mk(MN_OR,   FM_RR, CC_Z);
            6'h05:   d = mk(MN_OR,   FM_RC, CC_Z);
            6'h06:   d = mk(MN_XOR,  FM_RR, CC_Z);
            6'h07:   d = mk(MN_XOR,  FM_RC, CC_Z);
            6'h0C:   d = mk(MN_TEST, FM_RR, CC_Z);
            6'h0D:   d = mk(MN_TEST, FM_RC, CC_Z);
            6'h0E:   d = mk(MN_TSTC, FM_RR, CC_Z);
            6'h0F:   d = mk(MN_TSTC, FM_RC, CC_Z);
            6'h10:   d = mk(MN_ADD,  FM_RR, CC_Z);
            6'h11:   d = mk(MN_ADD,  FM_RC, CC_Z);
            6'h12:   d = mk(MN_ADDC, FM_RR, CC_Z);
            6'h13:   d = mk(MN_ADDC, FM_RC, CC_Z);
            6'h18:   d = mk(MN_SUB,  FM_RR, CC_Z);
            6'h19:   d = mk(MN_SUB,  FM_RC, CC_Z);
            6'h1A:   d = mk(MN_SUBC, FM_RR, CC_Z);
            6'h1B:   d = mk(MN_SUBC, FM_RC, CC_Z);
            6'h1C:   d = mk(MN_COMP, FM_RR, CC_Z);
            6'h1D:   d = mk(MN_COMP, FM_RC, CC_Z);
            6'h1E:   d = mk(MN_CMPC, FM_RR, CC_Z);
            6'h1F:   d = mk(MN_CMPC, FM_RC, CC_Z);
            6'h14: begin
                if (c[7:4] != 4'h0) begin
                    d = mk(MN_CORE, FM_REG, CC_Z);
                end else begin
                    d = shift_code(c[3:0]);
                end
            end
            6'h22:   d = mk(MN_JUMP, FM_ADDR,  CC_Z);
            6'h32:   d = mk(MN_JUMP, FM_CADDR, CC_Z);
            6'h36:   d = mk(MN_JUMP, FM_CADDR, CC_NZ);
            6'h3A:   d = mk(MN_JUMP, FM_CADDR, CC_C);
            6'h3E:   d = mk(MN_JUMP, FM_CADDR, CC_NC);
            6'h26:   d = mk(MN_JUMP, FM_RR,    CC_Z);
            6'h20:   d = mk(MN_CALL, FM_ADDR,  CC_Z);
            6'h30:   d = mk(MN_CALL, FM_CADDR, CC_Z);
            6'h34:   d = mk(MN_CALL, FM_CADDR, CC_NZ);
            6'h38:   d = mk(MN_CALL, FM_CADDR, CC_C);
            6'h3C:   d = mk(MN_CALL, FM_CADDR, CC_NC);
            6'h24:   d = mk(MN_CALL, FM_RR,    CC_Z);
            6'h25:   d = mk(MN_RET,  FM_NONE,  CC_Z);
            6'h31:   d = mk(MN_RET,  FM_COND,  CC_Z);
            6'h35:   d = mk(MN_RET,  FM_COND,  CC_NZ);
            6'h39:   d = mk(MN_RET,  FM_COND,  CC_C);
            6'h3D:   d = mk(MN_RET,  FM_COND,  CC_NC);
            6'h21:   d = mk(MN_RET,  FM_RC,    CC_Z);
            6'h2E:   d = mk(MN_ST,   FM_RR,    CC_Z);
            6'h2F:   d = mk(MN_ST,   FM_RC,    CC_Z);
            6'h0A:   d = mk(MN_LD,   FM_RR,    CC_Z);
            6'h0B:   d = mk(MN_LD,   FM_RC,    CC_Z);
            6'h2C:   d = mk(MN_OUT,  FM_RR,    CC_Z);
            6'h2D:   d = mk(MN_OUT,  FM_RC,    CC_Z);
            6'h2B:   d = mk(MN_OUTK, FM_CNIB,  CC_Z);
            6'h08:   d = mk(MN_IN,   FM_RR,    CC_Z);
            6'h09:   d = mk(MN_IN,   FM_RC,    CC_Z);
            default: d = mk(MN_UNK,  FM_RAW,   CC_Z);
        endcase
        if (c == NEW_DINT) begin
            d = mk(MN_DINT, FM_NONE, CC_Z);
        end else if (c == NEW_EINT) begin
            d = mk(MN_EINT, FM_NONE, CC_Z);
        end else if (c == NEW_RETI0 || c == NEW_RETI1) begin
            d = mk(MN_RETI, FM_FLAG, CC_Z);
        end else if (c == NEW_BANK0 || c == NEW_BANK1) begin
            d = mk(MN_BANK, FM_FLAG, CC_Z);
        end
        return d;
    endfunction

endpackage

>>> rtl/core/isd_front.sv
`timescale 1ns / 1ps

module isd_front
    import isd_pkg::*;
#(
    parameter int unsigned P_MEM_DEPTH = MEMORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_isa_mode,
    input  logic              i_accept,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WORD_W-1:0] i_word,
    output t_q_wr             o_wr
);

    localparam logic [ADDR_W:0] LIMIT_NEW = (ADDR_W + 1)'(P_MEM_DEPTH);
    localparam logic [ADDR_W:0] LIMIT_OLD = (ADDR_W + 1)'(OLD_DEPTH);

    t_region r_region;
    t_region n_region;

    logic in_space;
    logic zero_word;

    // Words beyond the active program space are dropped without effect.
    assign in_space  = ({1'b0, i_addr} < (i_isa_mode ? LIMIT_NEW : LIMIT_OLD));
    assign zero_word = (i_word == '0);

    always_comb begin
        n_region = r_region;
        if (i_accept && in_space) begin
            case (r_region)
                RG_IDLE: begin
                    if (!zero_word) begin
                        n_region = (i_addr == SCRATCH_ADDR) ? RG_DATA : RG_CODE;
                    end
                end
                RG_CODE, RG_DATA: begin
                    if (zero_word) begin
                        n_region = RG_IDLE;
                    end
                end
                default: n_region = RG_IDLE;
            endcase
        end
    end

    always_comb begin
        o_wr.push          = i_accept && in_space && !zero_word;
        o_wr.entry.dir     = (r_region == RG_IDLE);
        o_wr.entry.scratch = (i_addr == SCRATCH_ADDR);
        o_wr.entry.data    = (r_region == RG_IDLE) ? (i_addr == SCRATCH_ADDR)
                                                   : (r_region == RG_DATA);
        o_wr.entry.mode    = i_isa_mode;
        o_wr.entry.addr    = i_addr;
        o_wr.entry.word    = i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= RG_IDLE;
        end else begin
            r_region <= n_region;
        end
    end

endmodule

>>> rtl/core/isd_queue.sv
`timescale 1ns / 1ps

module isd_queue
    import isd_pkg::*;
#(
    parameter int unsigned P_DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_wr    i_wr,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_q_entry o_head
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);

    t_q_entry         r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr.push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.push && o_full))
        else $error("queue written while full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

>>> rtl/core/isd_back.sv
`timescale 1ns / 1ps

module isd_back
    import isd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_q_entry i_head,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_stall,
    output t_result  o_result
);

    logic    r_phase;
    logic    n_phase;
    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    t_result n_result;
    logic    load;
    logic    show_dir;
    t_dec    dec;

    // A new result may enter the output register when it is empty or
    // its current content is being transferred.
    assign load     = (!r_valid || !i_stall) && !i_empty;
    assign show_dir = i_head.dir && !r_phase;
    assign o_pop    = load && !show_dir;
    assign dec      = i_head.mode ? decode_new(i_head.word) : decode_old(i_head.word);

    always_comb begin
        n_result = '0;
        if (show_dir) begin
            n_result.record_kind    = i_head.scratch ? KIND_SCRATCH : KIND_ORIGIN;
            n_result.target_address = i_head.addr;
        end else if (i_head.data) begin
            n_result.record_kind   = KIND_DATA;
            n_result.constant_byte = i_head.word[7:0];
            n_result.data_high     = i_head.word[15:8];
            n_result.raw_word      = i_head.word;
            n_result.last_of_run   = 1'b1;
        end else begin
            n_result.record_kind  = KIND_INSTR;
            n_result.mnemonic     = dec.mnem;
            n_result.operand_form = dec.form;
            n_result.raw_word     = i_head.word;
            n_result.last_of_run  = 1'b1;
            case (dec.form)
                FM_RR: begin
                    n_result.first_reg  = i_head.word[11:8];
                    n_result.second_reg = i_head.word[7:4];
                end
                FM_RC: begin
                    n_result.first_reg     = i_head.word[11:8];
                    n_result.constant_byte = i_head.word[7:0];
                end
                FM_REG: begin
                    n_result.first_reg = i_head.word[11:8];
                end
                FM_ADDR: begin
                    n_result.target_address = i_head.mode ? i_head.word[11:0]
                                                          : {2'b00, i_head.word[9:0]};
                end
                FM_CADDR: begin
                    n_result.condition      = dec.cond;
                    n_result.target_address = i_head.mode ? i_head.word[11:0]
                                                          : {2'b00, i_head.word[9:0]};
                end
                FM_COND: begin
                    n_result.condition = dec.cond;
                end
                FM_CNIB: begin
                    n_result.constant_byte = i_head.word[11:4];
                    n_result.small_value   = i_head.word[3:0];
                end
                FM_FLAG: begin
                    n_result.small_value = {3'b000, i_head.word[0]};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        if (load) begin
            n_valid = 1'b1;
            n_phase = show_dir;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The word that opened a region stays at the head until its own record is sent.
    a_phase_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_empty)
        else $error("directive sent but opening word left the queue");

    a_dir_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.record_kind == KIND_ORIGIN ||
                     r_result.record_kind == KIND_SCRATCH)) |-> !r_result.last_of_run)
        else $error("directive marked as last of run");

    a_dir_followed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && (r_result.record_kind == KIND_ORIGIN ||
                                 r_result.record_kind == KIND_SCRATCH))
        |=> (r_valid && r_result.last_of_run))
        else $error("directive not followed by its record");

endmodule

>>> rtl/core/soft_cpu_instruction_stream_decoder_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// cfg      | in        | i_cfg_we               | i_cfg_data (isa mode)
// in       | in        | i_in_valid / o_in_stall | i_word_address, i_instruction_word
// out      | out       | o_out_valid / i_out_stall | o_record_kind ... o_last_of_run
//
// One word is taken per cycle while o_in_stall is low; its record goes via the queue to the output register.
// A word that opens a region gives two records: a directive record and then its own record.
// A four-entry queue between the classifying front end and the decoding back end
// absorbs those extra records and output stalls; o_in_stall rises only when it is full.
// Reset is synchronous and active low; it clears the region state, the queue and the mode.

module soft_cpu_instruction_stream_decoder_unit
    import isd_pkg::*;
#(
    parameter int unsigned P_MEM_DEPTH = MEMORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ADDR_W-1:0] i_word_address,
    input  logic [WORD_W-1:0] i_instruction_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_record_kind,
    output logic [5:0]        o_mnemonic,
    output logic [3:0]        o_operand_form,
    output logic [3:0]        o_first_reg,
    output logic [3:0]        o_second_reg,
    output logic [7:0]        o_constant_byte,
    output logic [ADDR_W-1:0] o_target_address,
    output logic [1:0]        o_condition,
    output logic [3:0]        o_small_value,
    output logic [7:0]        o_data_high,
    output logic [WORD_W-1:0] o_raw_word,
    output logic              o_last_of_run
);

    logic     r_isa_mode;
    logic     in_accept;
    t_q_wr    q_wr;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    t_q_entry q_head;
    t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isa_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_isa_mode <= i_cfg_data;
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    isd_front #(
        .P_MEM_DEPTH (P_MEM_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_isa_mode (r_isa_mode),
        .i_accept   (in_accept),
        .i_addr     (i_word_address),
        .i_word     (i_instruction_word),
        .o_wr       (q_wr)
    );

    isd_queue #(
        .P_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    isd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_record_kind    = result.record_kind;
    assign o_mnemonic       = result.mnemonic;
    assign o_operand_form   = result.operand_form;
    assign o_first_reg      = result.first_reg;
    assign o_second_reg     = result.second_reg;
    assign o_constant_byte  = result.constant_byte;
    assign o_target_address = result.target_address;
    assign o_condition      = result.condition;
    assign o_small_value    = result.small_value;
    assign o_data_high      = result.data_high;
    assign o_raw_word       = result.raw_word;
    assign o_last_of_run    = result.last_of_run;

endmodule
